// ===== rtl/hbf_pkg.sv =====
// Package for the hierarchical bitmap finder: sizing constants, request modes,
// and the command/status structs between controller and datapath.
// No dependencies.
package hbf_pkg;

  // Leaf words are a power of two wide so that word and bit split by shift and mask.
  localparam int WORD_SHIFT = 6;
  localparam int WORD_BITS  = 1 << WORD_SHIFT;
  localparam int WORD_COUNT = 64;
  localparam int TOTAL_BITS = WORD_BITS * WORD_COUNT;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam int MODE_W = 3;
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int BW_W   = CNT_W - WORD_SHIFT;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4096);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 3'd0,
    MODE_CLEAR = 3'd1,
    MODE_FIRST = 3'd2,
    MODE_NEXT  = 3'd3,
    MODE_LAST  = 3'd4
  } mode_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic eval1;
    logic eval2;
    logic push;
  } hbf_cmd_t;

  typedef struct packed {
    logic more;
  } hbf_sts_t;

endpackage

// ===== rtl/hbf_req_if.sv =====
// Request channel: valid/ready with mode and bit index.
// Depends on hbf_pkg.
interface hbf_req_if;
  logic                        valid;
  logic                        ready;
  logic [hbf_pkg::MODE_W-1:0]  mode;
  logic [hbf_pkg::POS_W-1:0]   bit_index;

  modport source (output valid, output mode, output bit_index, input ready);
  modport sink   (input valid, input mode, input bit_index, output ready);
endinterface

// ===== rtl/hbf_res_if.sv =====
// Result channel: valid/ready with found flag, position and index error.
// Depends on hbf_pkg.
interface hbf_res_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [hbf_pkg::POS_W-1:0]   position;
  logic                        index_error;

  modport source (output valid, output found, output position, output index_error,
                  input ready);
  modport sink   (input valid, input found, input position, input index_error,
                  output ready);
endinterface

// ===== rtl/hbf_cfg_if.sv =====
// Configuration write channel: valid/ready carrying the bit count register.
// Depends on hbf_pkg.
interface hbf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hbf_pkg::CNT_W-1:0]   bit_count;

  modport source (output valid, output bit_count, input ready);
  modport sink   (input valid, input bit_count, output ready);
endinterface

// ===== rtl/hbf_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module hbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rd_data_r <= mem_r[addr];
  end

endmodule

// ===== rtl/hbf_ctrl.sv =====
// Controller for the hierarchical bitmap finder: sequences one request through
// issue, evaluate and result push. Depends on hbf_pkg.
module hbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hbf_pkg::hbf_sts_t sts,
  output hbf_pkg::hbf_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_EVAL1 = 5'b00100,
    S_EVAL2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_EVAL1;
      end
      S_EVAL1: begin
        cmd.eval1 = 1'b1;
        state_nxt = sts.more ? S_EVAL2 : S_DONE;
      end
      S_EVAL2: begin
        cmd.eval2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/hbf_dpath.sv =====
// Datapath for the hierarchical bitmap finder: leaf word RAM, per-word valid
// flags, summary word, bound logic and result registers. Depends on hbf_pkg, hbf_ram.
module hbf_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hbf_pkg::hbf_cmd_t          cmd,
  output hbf_pkg::hbf_sts_t          sts,
  input  logic [hbf_pkg::MODE_W-1:0] in_mode,
  input  logic [hbf_pkg::POS_W-1:0]  in_bit_index,
  input  logic                       cfg_we,
  input  logic [hbf_pkg::CNT_W-1:0]  cfg_bit_count,
  output logic                       out_found,
  output logic [hbf_pkg::POS_W-1:0]  out_position,
  output logic                       out_index_error
);

  function automatic logic [hbf_pkg::WORD_SHIFT-1:0] lo_bit(
    input logic [hbf_pkg::WORD_BITS-1:0] v);
    logic [hbf_pkg::WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = hbf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = hbf_pkg::WORD_SHIFT'(i);
    end
    return r;
  endfunction

  function automatic logic [hbf_pkg::WORD_SHIFT-1:0] hi_bit(
    input logic [hbf_pkg::WORD_BITS-1:0] v);
    logic [hbf_pkg::WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = 0; i < hbf_pkg::WORD_BITS; i++) begin
      if (v[i]) r = hbf_pkg::WORD_SHIFT'(i);
    end
    return r;
  endfunction

  function automatic logic [hbf_pkg::WIDX_W-1:0] lo_word(
    input logic [hbf_pkg::WORD_COUNT-1:0] v);
    logic [hbf_pkg::WIDX_W-1:0] r;
    r = '0;
    for (int i = hbf_pkg::WORD_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = hbf_pkg::WIDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [hbf_pkg::WIDX_W-1:0] hi_word(
    input logic [hbf_pkg::WORD_COUNT-1:0] v);
    logic [hbf_pkg::WIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < hbf_pkg::WORD_COUNT; i++) begin
      if (v[i]) r = hbf_pkg::WIDX_W'(i);
    end
    return r;
  endfunction

  // Bits of leaf word w below the bound (bound split into word and remainder).
  function automatic logic [hbf_pkg::WORD_BITS-1:0] word_mask(
    input logic [hbf_pkg::WIDX_W-1:0]     w,
    input logic [hbf_pkg::BW_W-1:0]       bw,
    input logic [hbf_pkg::WORD_SHIFT-1:0] rem);
    logic [hbf_pkg::BW_W-1:0]      wx;
    logic [hbf_pkg::WORD_BITS-1:0] m;
    wx = hbf_pkg::BW_W'(w);
    if (wx < bw) begin
      m = '1;
    end else if (wx == bw) begin
      m = ~({hbf_pkg::WORD_BITS{1'b1}} << rem);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [hbf_pkg::POS_W-1:0] make_pos(
    input logic [hbf_pkg::WIDX_W-1:0]     w,
    input logic [hbf_pkg::WORD_SHIFT-1:0] b);
    return (hbf_pkg::POS_W'(w) << hbf_pkg::WORD_SHIFT) | hbf_pkg::POS_W'(b);
  endfunction

  // request and configuration registers
  logic [hbf_pkg::MODE_W-1:0]     mode_r;
  logic [hbf_pkg::POS_W-1:0]      idx_r;
  logic [hbf_pkg::CNT_W-1:0]      bit_count_r;
  logic [hbf_pkg::WIDX_W-1:0]     addr_r;
  logic                           any1_r;
  logic                           vld_q_r;
  logic [hbf_pkg::WORD_COUNT-1:0] valid_r;
  logic [hbf_pkg::WORD_COUNT-1:0] summary_r;
  logic                           res_found_r, res_err_r;
  logic [hbf_pkg::POS_W-1:0]      res_pos_r;
  logic                           out_found_r, out_err_r;
  logic [hbf_pkg::POS_W-1:0]      out_pos_r;

  logic [hbf_pkg::CNT_W-1:0]      bound, start;
  logic [hbf_pkg::BW_W-1:0]       bw;
  logic [hbf_pkg::WORD_SHIFT-1:0] rem, start_rem;
  logic [hbf_pkg::WORD_COUNT-1:0] usable, cand, above, below, vec2;
  logic                           is_set, is_clear, is_first, is_next, is_last, is_wr;
  logic                           idx_ok, start_ok, has2, more;
  logic [hbf_pkg::WIDX_W-1:0]     addr1, addr2, ram_addr;
  logic                           any1;
  logic [hbf_pkg::WORD_BITS-1:0]  rd_data, word, mask_w, v1, v2, bit_sel, new_word;
  logic                           ram_we;
  logic                           found1, found2;
  logic [hbf_pkg::POS_W-1:0]      pos1, pos2;

  assign is_set   = (mode_r == hbf_pkg::MODE_SET);
  assign is_clear = (mode_r == hbf_pkg::MODE_CLEAR);
  assign is_first = (mode_r == hbf_pkg::MODE_FIRST);
  assign is_next  = (mode_r == hbf_pkg::MODE_NEXT);
  assign is_last  = (mode_r == hbf_pkg::MODE_LAST);
  assign is_wr    = is_set | is_clear;

  // saturate the bound at the store capacity
  assign bound = (bit_count_r > hbf_pkg::CNT_W'(hbf_pkg::TOTAL_BITS)) ?
                 hbf_pkg::CNT_W'(hbf_pkg::TOTAL_BITS) : bit_count_r;
  assign bw    = hbf_pkg::BW_W'(bound >> hbf_pkg::WORD_SHIFT);
  assign rem   = bound[hbf_pkg::WORD_SHIFT-1:0];

  assign start     = {1'b0, idx_r} + hbf_pkg::CNT_W'(1);
  assign start_rem = start[hbf_pkg::WORD_SHIFT-1:0];
  assign idx_ok    = ({1'b0, idx_r} < bound);
  assign start_ok  = (start < bound);

  always_comb begin
    for (int w = 0; w < hbf_pkg::WORD_COUNT; w++) begin
      usable[w] = (hbf_pkg::BW_W'(w) < bw) || ((hbf_pkg::BW_W'(w) == bw) && (rem != '0));
      above[w]  = (hbf_pkg::WIDX_W'(w) > addr_r);
      below[w]  = (hbf_pkg::WIDX_W'(w) < addr_r);
    end
  end

  assign cand = summary_r & usable;

  // first word to read
  always_comb begin
    addr1 = '0;
    any1  = 1'b0;
    case (mode_r) inside
      hbf_pkg::MODE_SET, hbf_pkg::MODE_CLEAR: begin
        addr1 = hbf_pkg::WIDX_W'(idx_r >> hbf_pkg::WORD_SHIFT);
        any1  = idx_ok;
      end
      hbf_pkg::MODE_FIRST: begin
        addr1 = lo_word(cand);
        any1  = |cand;
      end
      hbf_pkg::MODE_NEXT: begin
        addr1 = hbf_pkg::WIDX_W'(start >> hbf_pkg::WORD_SHIFT);
        any1  = start_ok;
      end
      hbf_pkg::MODE_LAST: begin
        addr1 = hi_word(cand);
        any1  = |cand;
      end
      default: begin
        addr1 = '0;
        any1  = 1'b0;
      end
    endcase
  end

  // never-written words read as zero
  assign word   = rd_data & {hbf_pkg::WORD_BITS{vld_q_r}};
  assign mask_w = word_mask(addr_r, bw, rem);

  assign v1 = is_next ? (word & mask_w & ({hbf_pkg::WORD_BITS{1'b1}} << start_rem))
                      : (word & mask_w);
  assign v2 = word & mask_w;

  // second candidate word, past the one just read
  assign vec2  = is_next ? (cand & above) : (cand & below);
  assign has2  = |vec2;
  assign addr2 = is_next ? lo_word(vec2) : hi_word(vec2);
  assign more  = (is_next | is_last) & any1_r & (v1 == '0) & has2;
  assign sts.more = more;

  assign found1 = (is_first | is_next | is_last) & any1_r & (v1 != '0);
  assign pos1   = found1 ? make_pos(addr_r, is_last ? hi_bit(v1) : lo_bit(v1)) : '0;
  assign found2 = (v2 != '0);
  assign pos2   = found2 ? make_pos(addr_r, is_last ? hi_bit(v2) : lo_bit(v2)) : '0;

  assign bit_sel  = hbf_pkg::WORD_BITS'(1) << idx_r[hbf_pkg::WORD_SHIFT-1:0];
  assign new_word = is_set ? (word | bit_sel) : (word & ~bit_sel);
  assign ram_we   = cmd.eval1 & is_wr & any1_r;

  always_comb begin
    if (cmd.issue) begin
      ram_addr = addr1;
    end else if (cmd.eval1 && more) begin
      ram_addr = addr2;
    end else begin
      ram_addr = addr_r;
    end
  end

  hbf_ram #(
    .WIDTH (hbf_pkg::WORD_BITS),
    .DEPTH (hbf_pkg::WORD_COUNT)
  ) u_leaf_ram (
    .clk       (clk),
    .we        (ram_we),
    .addr      (ram_addr),
    .wdata     (new_word),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    vld_q_r <= valid_r[ram_addr];
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_bit_index;
    end
    if (cmd.issue) begin
      addr_r <= addr1;
      any1_r <= any1;
    end else if (cmd.eval1 && more) begin
      addr_r <= addr2;
    end
    if (cmd.eval1) begin
      res_found_r <= found1;
      res_pos_r   <= pos1;
      res_err_r   <= is_wr & ~any1_r;
    end
    if (cmd.eval2) begin
      res_found_r <= found2;
      res_pos_r   <= pos2;
      res_err_r   <= 1'b0;
    end
    if (cmd.push) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_pos_r;
      out_err_r   <= res_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      summary_r   <= '0;
      bit_count_r <= hbf_pkg::CNT_RESET;
    end else begin
      if (cfg_we) begin
        bit_count_r <= cfg_bit_count;
      end
      if (ram_we) begin
        valid_r[addr_r]   <= 1'b1;
        summary_r[addr_r] <= |new_word;
      end
    end
  end

  assign out_found       = out_found_r;
  assign out_position    = out_pos_r;
  assign out_index_error = out_err_r;

endmodule

// ===== rtl/hierarchical_bitmap_finder.sv =====
// Two-level bitmap with set, clear and find first/next/last requests.
// The controller steps through accept, leaf RAM issue, evaluate (a second evaluate when a search
// reads a second leaf word) and result push, and holds the push while a result waits; it takes
// a new request only once it is back in idle after the push.
// Reset: synchronous, active low; clears the summary word and per-word valid flags
// at once (leaf store reads as zero), bit count returns to 4096.
module hierarchical_bitmap_finder (
  input  logic     clk,
  input  logic     rst_n,
  hbf_req_if.sink   in_ch,
  hbf_res_if.source out_ch,
  hbf_cfg_if.sink   cfg_ch
);

  hbf_pkg::hbf_cmd_t cmd;
  hbf_pkg::hbf_sts_t sts;

  // configuration writes must only arrive while idle; the block itself does not enforce this
  assign cfg_ch.ready = 1'b1;

  hbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_ch.mode),
    .in_bit_index    (in_ch.bit_index),
    .cfg_we          (cfg_ch.valid),
    .cfg_bit_count   (cfg_ch.bit_count),
    .out_found       (out_ch.found),
    .out_position    (out_ch.position),
    .out_index_error (out_ch.index_error)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for hierarchical_bitmap_finder: set/clear/find requests and
// bit count writes, with every result checked against an in-bench bitmap model.
// Depends on hbf_pkg and the hbf_req_if, hbf_res_if and hbf_cfg_if interfaces.
module testbench;
  import hbf_pkg::*;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_COUNT-1:0] summary_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             index_error;
  } bitmap_result_t;

  // Modes outside the enum that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned MAX_INDEX = TOTAL_BITS - 1;

  class bitmap_scoreboard;
    word_t          leaf [WORD_COUNT];
    summary_t       summary;
    int unsigned    bit_count;
    bitmap_result_t expected_results [$];
    int unsigned    errors;

    function new();
      foreach (leaf[i]) leaf[i] = '0;
      summary   = '0;
      bit_count = CNT_RESET;
      errors    = 0;
    endfunction

    function int unsigned bound();
      return (bit_count > TOTAL_BITS) ? TOTAL_BITS : bit_count;
    endfunction

    // Bits of leaf word w that lie below the bound.
    function word_t usable(int unsigned w, int unsigned b);
      int unsigned lo;
      lo = w * WORD_BITS;
      if (b <= lo) return '0;
      if (b - lo >= WORD_BITS) return '1;
      return (word_t'(1) << (b - lo)) - word_t'(1);
    endfunction

    function int unsigned lowest_set(word_t v);
      for (int unsigned i = 0; i < WORD_BITS; i++)
        if (v[i]) return i;
      return 0;
    endfunction

    function int unsigned highest_set(word_t v);
      for (int i = WORD_BITS - 1; i >= 0; i--)
        if (v[i]) return i;
      return 0;
    endfunction

    function bit scan_upward(int unsigned w0, word_t first_mask, int unsigned b,
                             output int unsigned pos);
      word_t m;
      word_t v;
      m   = first_mask;
      pos = 0;
      for (int unsigned w = w0; w < WORD_COUNT; w++) begin
        if (summary[w]) begin
          v = leaf[w] & usable(w, b) & m;
          if (v != '0) begin
            pos = w * WORD_BITS + lowest_set(v);
            return 1'b1;
          end
        end
        m = '1;
      end
      return 1'b0;
    endfunction

    function bitmap_result_t apply_request(logic [MODE_W-1:0] mode, int unsigned idx);
      bitmap_result_t r;
      int unsigned    b;
      int unsigned    w;
      int unsigned    start;
      int unsigned    pos;
      word_t          old;
      word_t          m;
      word_t          v;
      r   = '0;
      pos = 0;
      b   = bound();
      case (mode)
        MODE_SET, MODE_CLEAR: begin
          if (idx >= b) begin
            r.index_error = 1'b1;
          end else begin
            w   = idx / WORD_BITS;
            old = leaf[w];
            if (mode == MODE_SET) begin
              leaf[w][idx % WORD_BITS] = 1'b1;
              if (old == '0) summary[w] = 1'b1;
            end else begin
              leaf[w][idx % WORD_BITS] = 1'b0;
              if (old != '0 && leaf[w] == '0) summary[w] = 1'b0;
            end
          end
        end
        MODE_FIRST: r.found = scan_upward(0, '1, b, pos);
        MODE_NEXT: begin
          start = idx + 1;
          if (start < b) begin
            m = '1;
            m = m << (start % WORD_BITS);
            r.found = scan_upward(start / WORD_BITS, m, b, pos);
          end
        end
        MODE_LAST: begin
          for (int i = WORD_COUNT - 1; i >= 0 && !r.found; i--) begin
            if (summary[i]) begin
              v = leaf[i] & usable(i, b);
              if (v != '0) begin
                pos     = i * WORD_BITS + highest_set(v);
                r.found = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      if (r.found) r.position = pos[POS_W-1:0];
      return r;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] idx);
      expected_results.push_back(apply_request(mode, idx));
    endfunction

    function void check_result(logic found, logic [POS_W-1:0] position, logic index_error);
      bitmap_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: found %0d position %0d index_error %0d",
               found, position, index_error);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (position !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, position);
        errors++;
      end
      if (index_error !== e.index_error) begin
        $error("index_error: expected %0d, got %0d", e.index_error, index_error);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hbf_req_if req_ch ();
  hbf_res_if res_ch ();
  hbf_cfg_if cfg_ch ();

  hierarchical_bitmap_finder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  bitmap_scoreboard sb = new();

  bit          quiet_phase;
  int unsigned stall_left;
  int unsigned stall_len;
  int unsigned recent_set [$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.found, res_ch.position, res_ch.index_error);
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        stall_len    = pick_gap();
        res_ch.ready <= (stall_len == 0);
        stall_left   <= (stall_len == 0) ? 0 : stall_len - 1;
      end
    end
  end

  task automatic send_request(logic [MODE_W-1:0] mode, int unsigned idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.bit_index <= idx[POS_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(mode, idx[POS_W-1:0]);
  endtask

  // Drain every result and pause before touching the register.
  task automatic write_bit_count(logic [CNT_W-1:0] value);
    req_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.bit_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.bit_count = value;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_SET;
    if (r < 50) return MODE_CLEAR;
    if (r < 60) return MODE_FIRST;
    if (r < 82) return MODE_NEXT;
    if (r < 94) return MODE_LAST;
    return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endfunction

  // Aim at the bound, at a window of a few words, or anywhere.
  function automatic int unsigned pick_index(int unsigned b, int unsigned window_lo);
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      lo = (b > 3) ? b - 3 : 0;
      hi = (b + 2 > MAX_INDEX) ? MAX_INDEX : b + 2;
      if (lo > MAX_INDEX) lo = MAX_INDEX;
      return $urandom_range(lo, hi);
    end
    if (r < 75) begin
      hi = window_lo + 3 * WORD_BITS - 1;
      return $urandom_range(window_lo, (hi > MAX_INDEX) ? MAX_INDEX : hi);
    end
    return $urandom_range(0, MAX_INDEX);
  endfunction

  task automatic run_phase(logic [CNT_W-1:0] count_value, int unsigned items);
    int unsigned       b;
    int unsigned       window_lo;
    int unsigned       idx;
    logic [MODE_W-1:0] mode;
    write_bit_count(count_value);
    b           = (count_value > TOTAL_BITS) ? TOTAL_BITS : count_value;
    window_lo   = $urandom_range(0, WORD_COUNT - 1) * WORD_BITS;
    // Sometimes start the window at the word that holds the last bit below a partial bound.
    if (b > 0 && b < TOTAL_BITS && $urandom_range(0, 1) == 1)
      window_lo = ((b - 1) / WORD_BITS) * WORD_BITS;
    quiet_phase = ($urandom_range(0, 3) == 0);
    repeat (items) begin
      mode = pick_mode();
      idx  = pick_index(b, window_lo);
      if (mode == MODE_CLEAR && recent_set.size() != 0 && $urandom_range(0, 1) == 1)
        idx = recent_set[$urandom_range(0, recent_set.size() - 1)];
      send_request(mode, idx);
      if (mode == MODE_SET) begin
        recent_set.push_back(idx);
        if (recent_set.size() > 16) void'(recent_set.pop_front());
      end
    end
    quiet_phase = 1'b0;
  endtask

  logic [CNT_W-1:0] phase_counts [$];
  int unsigned      waited;

  initial begin
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_SET;
    req_ch.bit_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.bit_count <= CNT_RESET;
    quiet_phase      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset bit count.
    send_request(MODE_FIRST, 0);
    send_request(MODE_LAST, 0);
    send_request(MODE_NEXT, 0);
    send_request(MODE_SET, 0);
    send_request(MODE_SET, MAX_INDEX);
    send_request(MODE_SET, WORD_BITS - 1);
    send_request(MODE_SET, WORD_BITS);
    send_request(MODE_SET, TOTAL_BITS / 2 - 1);
    send_request(MODE_FIRST, 0);
    send_request(MODE_LAST, 0);
    send_request(MODE_NEXT, 0);
    send_request(MODE_NEXT, WORD_BITS - 1);
    send_request(MODE_NEXT, MAX_INDEX - 1);
    send_request(MODE_NEXT, MAX_INDEX);
    send_request(MODE_SET, WORD_BITS - 1);
    send_request(MODE_CLEAR, WORD_BITS);
    send_request(MODE_NEXT, WORD_BITS - 1);
    send_request(MODE_CLEAR, 100);
    send_request(MODE_SPARE_LO, MAX_INDEX);
    send_request(MODE_W'(MODE_SPARE_LO + 1), 12'hAAA);
    send_request(MODE_SPARE_HI, 12'h555);
    send_request(MODE_CLEAR, 0);
    send_request(MODE_FIRST, 0);
    send_request(MODE_CLEAR, MAX_INDEX);
    send_request(MODE_LAST, 0);

    phase_counts = '{13'd4096, 13'd0, 13'd1, 13'd64, 13'd65, 13'd8191, 13'd4097,
                     13'd127, 13'd4095, 13'd2000, 13'd63,
                     CNT_W'($urandom_range(1, 4096)), CNT_W'($urandom_range(0, 8191)),
                     13'd4096};
    foreach (phase_counts[i])
      run_phase(phase_counts[i], 118);

    req_ch.valid <= 1'b0;
    waited = 0;
    while (sb.expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_results.size() != 0) begin
      $error("%0d results never arrived", sb.expected_results.size());
      sb.errors++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
